@@ sv/sod_pkg.sv @@
// ----------------------------------------------------------------------------
// sod_pkg: shared types and constants of the sweep object detector
// Ring geometry, register codes and the structs that pass between modules.
// ----------------------------------------------------------------------------
package sod_pkg;

    // depth of the distance averaging ring (1 to 16)
    localparam int AVG_DEPTH = 4;
    localparam int IDX_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W     = 16 + $clog2(AVG_DEPTH);

    localparam int ANGLE_W   = 8;
    localparam int DIST_W    = 16;
    localparam int IR_W      = 12;
    localparam int COUNT_W   = 7;
    localparam int PROD_W    = 24;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IR_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT   = 1'b1;

    localparam logic [IR_W-1:0]    IR_THRESHOLD_RESET = 12'd900;
    localparam logic [DIST_W-1:0]  NEAR_LIMIT_RESET   = 16'd3840;
    localparam logic [COUNT_W-1:0] COUNT_MAX          = 7'd127;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    typedef struct packed {
        logic [IR_W-1:0]   ir_threshold;
        logic [DIST_W-1:0] near_limit;
    } sod_cfg_t;

    typedef struct packed {
        logic [DIST_W-1:0]  best_distance;
        logic [ANGLE_W-1:0] best_width;
        logic [ANGLE_W-1:0] best_angle;
        logic               found;
        logic [COUNT_W-1:0] object_count;
    } sod_result_t;

endpackage

@@ sv/sod_ring.sv @@
// ----------------------------------------------------------------------------
// sod_ring: distance ring with running sum
// Holds the last AVG_DEPTH distances and gives the ring sum including the
// item being processed.
// ----------------------------------------------------------------------------
module sod_ring
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic                       start_of_scan,
    input  logic [sod_pkg::DIST_W-1:0] echo_distance,
    output logic [sod_pkg::SUM_W-1:0]  ring_sum
);
    import sod_pkg::*;

    logic [DIST_W-1:0] ring_reg [AVG_DEPTH];
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_use;
    logic [IDX_W-1:0]  idx_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_base;
    logic [SUM_W-1:0]  sum_old;
    logic [SUM_W-1:0]  sum_next;

    always_comb
    begin
        idx_use  = start_of_scan ? '0 : idx_reg;
        sum_base = start_of_scan ? '0 : sum_reg;
        sum_old  = start_of_scan ? '0 : SUM_W'(ring_reg[idx_reg]);
        // replace the oldest entry in the running sum
        sum_next = sum_base - sum_old + SUM_W'(echo_distance);
        if (idx_use == IDX_W'(AVG_DEPTH - 1))
        begin
            idx_next = '0;
        end
        else
        begin
            idx_next = idx_use + IDX_W'(1);
        end
    end

    assign ring_sum = sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AVG_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
            idx_reg <= '0;
            sum_reg <= '0;
        end
        else if (step)
        begin
            for (int i = 0; i < AVG_DEPTH; i++)
            begin
                if (idx_use == IDX_W'(i))
                begin
                    ring_reg[i] <= echo_distance;
                end
                else if (start_of_scan)
                begin
                    ring_reg[i] <= '0;
                end
            end
            idx_reg <= idx_next;
            sum_reg <= sum_next;
        end
    end

endmodule

@@ sv/sod_track.sv @@
// ----------------------------------------------------------------------------
// sod_track: object tracking and running best
// Opens and closes objects from the IR level and averaged distance, keeps the
// largest closed object and forms the scan summary.
// ----------------------------------------------------------------------------
module sod_track
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        start_of_scan,
    input  logic [sod_pkg::ANGLE_W-1:0] sweep_angle,
    input  logic [sod_pkg::IR_W-1:0]    ir_level,
    input  logic [sod_pkg::SUM_W-1:0]   ring_sum,
    input  sod_pkg::sod_cfg_t           cfg,
    output sod_pkg::sod_result_t        result
);
    import sod_pkg::*;

    logic               in_object_reg,     in_object_next,     in_object_base;
    logic [ANGLE_W-1:0] open_angle_reg,    open_angle_next,    open_angle_base;
    logic [DIST_W-1:0]  open_dist_reg,     open_dist_next,     open_dist_base;
    logic [COUNT_W-1:0] count_reg,         count_next,         count_base;
    logic [ANGLE_W-1:0] best_angle_reg,    best_angle_next,    best_angle_base;
    logic [ANGLE_W-1:0] best_width_reg,    best_width_next,    best_width_base;
    logic [DIST_W-1:0]  best_dist_reg,     best_dist_next,     best_dist_base;
    logic [PROD_W-1:0]  best_product_reg,  best_product_next,  best_product_base;
    logic               have_best_reg,     have_best_next,     have_best_base;

    logic               ir_present;
    logic               is_near;
    logic               opening;
    logic               closing;
    logic [ANGLE_W-1:0] width;
    logic [ANGLE_W:0]   angle_sum;
    logic [ANGLE_W-1:0] mid;
    logic [PROD_W-1:0]  product;
    logic               new_best;

    always_comb
    begin
        // a start item clears the scan before the sample is looked at
        if (start_of_scan)
        begin
            in_object_base    = 1'b0;
            open_angle_base   = '0;
            open_dist_base    = '0;
            count_base        = '0;
            best_angle_base   = '0;
            best_width_base   = '0;
            best_dist_base    = '0;
            best_product_base = '0;
            have_best_base    = 1'b0;
        end
        else
        begin
            in_object_base    = in_object_reg;
            open_angle_base   = open_angle_reg;
            open_dist_base    = open_dist_reg;
            count_base        = count_reg;
            best_angle_base   = best_angle_reg;
            best_width_base   = best_width_reg;
            best_dist_base    = best_dist_reg;
            best_product_base = best_product_reg;
            have_best_base    = have_best_reg;
        end

        ir_present = (ir_level >= cfg.ir_threshold);
        is_near    = (ring_sum < (SUM_W'(cfg.near_limit) * SUM_W'(AVG_DEPTH)));
        opening    = ir_present && !in_object_base && is_near;
        closing    = !ir_present && in_object_base;

        width     = sweep_angle - open_angle_base;
        angle_sum = {1'b0, open_angle_base} + {1'b0, sweep_angle};
        mid       = angle_sum[ANGLE_W:1];
        product   = PROD_W'(width) * PROD_W'(open_dist_base);
        new_best  = !have_best_base || (product > best_product_base);

        in_object_next    = in_object_base;
        open_angle_next   = open_angle_base;
        open_dist_next    = open_dist_base;
        count_next        = count_base;
        best_angle_next   = best_angle_base;
        best_width_next   = best_width_base;
        best_dist_next    = best_dist_base;
        best_product_next = best_product_base;
        have_best_next    = have_best_base;

        if (opening)
        begin
            in_object_next  = 1'b1;
            open_angle_next = sweep_angle;
            open_dist_next  = DIST_W'(ring_sum / SUM_W'(AVG_DEPTH));
            if (count_base != COUNT_MAX)
            begin
                count_next = count_base + COUNT_W'(1);
            end
        end
        else if (closing)
        begin
            in_object_next = 1'b0;
            if (new_best)
            begin
                have_best_next    = 1'b1;
                best_product_next = product;
                best_angle_next   = mid;
                best_width_next   = width;
                best_dist_next    = open_dist_base;
            end
        end

        result.object_count  = count_next;
        result.found         = (count_next != '0);
        result.best_angle    = have_best_next ? best_angle_next : '0;
        result.best_width    = have_best_next ? best_width_next : '0;
        result.best_distance = have_best_next ? best_dist_next  : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_object_reg    <= 1'b0;
            open_angle_reg   <= '0;
            open_dist_reg    <= '0;
            count_reg        <= '0;
            best_angle_reg   <= '0;
            best_width_reg   <= '0;
            best_dist_reg    <= '0;
            best_product_reg <= '0;
            have_best_reg    <= 1'b0;
        end
        else if (step)
        begin
            in_object_reg    <= in_object_next;
            open_angle_reg   <= open_angle_next;
            open_dist_reg    <= open_dist_next;
            count_reg        <= count_next;
            best_angle_reg   <= best_angle_next;
            best_width_reg   <= best_width_next;
            best_dist_reg    <= best_dist_next;
            best_product_reg <= best_product_next;
            have_best_reg    <= have_best_next;
        end
    end

endmodule

@@ sv/sweep_object_detector.sv @@
// ----------------------------------------------------------------------------
// sweep_object_detector: largest-object finder over one servo sweep
// Input register, combinational tracking update and registered result.
// ----------------------------------------------------------------------------
// Takes one sweep sample per cycle while the output is taken. An item is
// captured in an input register, then processed by the ring sum and object
// tracker (one 8x16 multiply and compare), and, when marked last, leaves as a
// summary item from the output register. The throughput is one item per
// clock for as long as the output is taken; a last item held up by a stalled
// output holds the input register and so the input side.
// Write configuration only while no items are in flight.
module sweep_object_detector
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sod_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sod_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] sweep_angle, [23:8] echo_distance, [35:24] ir_level, [39:36] zero
    input  logic [sod_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // start_of_scan
    input  logic                            s_axis_tuser,
    // last_of_scan
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [6:0] object_count, [7] found, [15:8] best_angle, [23:16] best_width,
    // [39:24] best_distance
    output logic [sod_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import sod_pkg::*;

    sod_cfg_t           cfg_reg;
    logic               in_valid_reg;
    logic               in_start_reg;
    logic               in_last_reg;
    logic [ANGLE_W-1:0] in_angle_reg;
    logic [DIST_W-1:0]  in_dist_reg;
    logic [IR_W-1:0]    in_ir_reg;
    logic               out_valid_reg;
    sod_result_t        out_data_reg;
    sod_result_t        result;
    logic [SUM_W-1:0]   ring_sum;
    logic               out_free;
    logic               step;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || step;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_data_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ir_threshold <= IR_THRESHOLD_RESET;
            cfg_reg.near_limit   <= NEAR_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IR_THRESHOLD: cfg_reg.ir_threshold <= cfg_data[IR_W-1:0];
                CFG_NEAR_LIMIT:   cfg_reg.near_limit   <= cfg_data[DIST_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_start_reg <= s_axis_tuser;
            in_last_reg  <= s_axis_tlast;
            in_angle_reg <= s_axis_tdata[7:0];
            in_dist_reg  <= s_axis_tdata[23:8];
            in_ir_reg    <= s_axis_tdata[35:24];
        end
    end

    sod_ring u_ring
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .start_of_scan (in_start_reg),
        .echo_distance (in_dist_reg),
        .ring_sum      (ring_sum)
    );

    sod_track u_track
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .start_of_scan (in_start_reg),
        .sweep_angle   (in_angle_reg),
        .ir_level      (in_ir_reg),
        .ring_sum      (ring_sum),
        .cfg           (cfg_reg),
        .result        (result)
    );

    // load a summary when a last item is processed, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && in_last_reg)
        begin
            out_data_reg <= result;
        end
    end

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> in_valid_reg)
        else $error("accepted item not held in input register");

    a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && in_last_reg && !out_free |=> in_valid_reg && in_last_reg)
        else $error("last item dropped while output stalled");

    a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.found == (out_data_reg.object_count != '0)))
        else $error("found flag disagrees with object count");

    a_best_needs_object: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.found |->
            (out_data_reg.best_width == '0) && (out_data_reg.best_distance == '0))
        else $error("best object reported with no object opened");

endmodule
